// ===== rtl/core/nested_priority_interrupt_controller_assert.svh =====
// Assertion macros for the nested priority interrupt controller.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef NESTED_PRIORITY_INTERRUPT_CONTROLLER_ASSERT_SVH
`define NESTED_PRIORITY_INTERRUPT_CONTROLLER_ASSERT_SVH
`ifndef SYNTHESIS
// The condition must hold at every clock edge out of reset.
`define NPIC_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// The consequent must hold in the same cycle as the antecedent.
`define NPIC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define NPIC_ASSERT(label, cond, msg)
`define NPIC_ASSERT_IMP(label, ante, cons, msg)
`endif
`endif

// ===== rtl/core/npic_pkg.sv =====
// Shared types, codes and the per-level enable decode of the interrupt controller.
// Has no dependencies.
package npic_pkg;

	localparam int NumSourcesDefault = 16;
	localparam int MaskW = 16;

	// Event kinds carried on the input stream.
	typedef enum logic [1:0] {
		FUNC_RAISE    = 2'd0,
		FUNC_BOUNDARY = 2'd1,
		FUNC_RETURN   = 2'd2
	} func_t;

	localparam logic [1:0] LVL_LOW     = 2'd0;
	localparam logic [1:0] LVL_HIGH    = 2'd1;
	localparam logic [1:0] LVL_HIGHEST = 2'd2;

	typedef struct packed {
		logic [MaskW-1:0] highest;
		logic [MaskW-1:0] high;
		logic [MaskW-1:0] low;
	} level_en_t;

	// Source number controlled by each priority bit; bit 6 has no source.
	localparam logic [3:0] IP_SRC [8] = '{4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd0, 4'd10};
	localparam int IP_UNUSED_BIT = 6;

	function automatic level_en_t level_enables(logic [7:0] ie, logic [7:0] ip);
		level_en_t en;
		en = '0;
		if (!ie[0]) en.highest[1] = 1'b1;
		if (!ie[0] && !ie[1]) en.highest[2] = 1'b1;
		for (int b = 0; b < 8; b++) begin
			if (b != IP_UNUSED_BIT) begin
				if (ip[b]) en.high[IP_SRC[b]] = 1'b1;
				if (!ip[b] && ie[7]) en.low[IP_SRC[b]] = 1'b1;
			end
		end
		if (ie[7] && ie[0]) begin
			en.low[1] = 1'b1;
			en.low[2] = 1'b1;
		end
		if (ie[7] && ie[1]) en.low[2] = 1'b1;
		return en;
	endfunction

endpackage

// ===== rtl/core/nested_priority_interrupt_controller.sv =====
// Top level of the three-level nested priority interrupt controller.
// Depends on npic_pkg and nested_priority_interrupt_controller_assert.svh.
//
// Channel  Direction  Payload
// s_*      in         tuser: func; tdata: irq_num, ie_bits, ip_bits
// m_*      out        tdata: taken, taken_irq, taken_level, reti_popped,
//                     active_mask, pending_mask
//
// One event is accepted every cycle unless an event waits in the input register
// behind an untaken result. The result register loads as the input register advances.
// The state update for an event is done combinationally between the two registers.
// Reset puts all state in its initial values at once; there is no clearing pass.
// When the result register is full and not taken, the input register holds
// and s_tready drops; the stall reaches s_tready in the same cycle.
module nested_priority_interrupt_controller #(
	parameter int NUM_SOURCES = npic_pkg::NumSourcesDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [3:0] irq_num, [11:4] ie_bits, [19:12] ip_bits, [23:20] zero
	input  logic [23:0] s_tdata,
	// [1:0] func
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] taken, [4:1] taken_irq, [6:5] taken_level, [7] reti_popped,
	// [23:8] active_mask, [39:24] pending_mask
	output logic [39:0] m_tdata
);
	import npic_pkg::*;

	localparam int NS = NUM_SOURCES;

	// Input register.
	logic        valid_s1;
	logic [1:0]  func_s1;
	logic [3:0]  irq_s1;
	logic [7:0]  ie_s1;
	logic [7:0]  ip_s1;

	// Controller state.
	logic [NS-1:0] req_q;
	logic [NS-1:0] slot_lo_q, slot_hi_q, slot_top_q;
	logic [1:0]    last_ret_q;
	logic          armed_q;

	// Result register.
	logic        out_valid_q;
	logic [39:0] out_data_q;

	logic advance;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Next-state and result logic for the event in the input register.
	level_en_t     en;
	logic [NS-1:0] hit_lo, hit_hi, hit_top;
	logic [NS-1:0] req_n, slot_lo_n, slot_hi_n, slot_top_n;
	logic [NS-1:0] pick_hit, pick_one;
	logic [1:0]    last_ret_n;
	logic          armed_n;
	logic          pick;
	logic [1:0]    pick_lvl;
	logic [3:0]    pick_idx;
	logic          popped;
	logic [NS-1:0] active_n;

	assign en      = level_enables(ie_s1, ip_s1);
	assign hit_lo  = en.low[NS-1:0] & req_q;
	assign hit_hi  = en.high[NS-1:0] & req_q;
	assign hit_top = en.highest[NS-1:0] & req_q;

	always_comb begin
		pick     = 1'b0;
		pick_lvl = LVL_LOW;
		pick_hit = '0;
		// Order of levels when nothing is active depends on the last return.
		if (!armed_q || func_s1 != FUNC_BOUNDARY) begin
			pick = 1'b0;
		end else if ((slot_lo_q | slot_hi_q | slot_top_q) == '0) begin
			if (last_ret_q == LVL_HIGH) begin
				if (|hit_lo) begin
					pick     = 1'b1;
					pick_lvl = LVL_LOW;
					pick_hit = hit_lo;
				end else if (|hit_hi) begin
					pick     = 1'b1;
					pick_lvl = LVL_HIGH;
					pick_hit = hit_hi;
				end
			end else begin
				if (|hit_hi) begin
					pick     = 1'b1;
					pick_lvl = LVL_HIGH;
					pick_hit = hit_hi;
				end else if (|hit_lo) begin
					pick     = 1'b1;
					pick_lvl = LVL_LOW;
					pick_hit = hit_lo;
				end
			end
		end else begin
			// Only levels above every active slot are searched.
			if (slot_top_q == '0 && (|hit_top)) begin
				pick     = 1'b1;
				pick_lvl = LVL_HIGHEST;
				pick_hit = hit_top;
			end else if (slot_top_q == '0 && slot_hi_q == '0 && (|hit_hi)) begin
				pick     = 1'b1;
				pick_lvl = LVL_HIGH;
				pick_hit = hit_hi;
			end
		end
	end

	// Lowest-numbered set bit of the chosen hit vector.
	always_comb begin
		pick_idx = '0;
		for (int i = NS - 1; i >= 0; i--) begin
			if (pick_hit[i]) pick_idx = 4'(i);
		end
	end

	assign pick_one = NS'(1) << pick_idx;

	always_comb begin
		req_n      = req_q;
		slot_lo_n  = slot_lo_q;
		slot_hi_n  = slot_hi_q;
		slot_top_n = slot_top_q;
		last_ret_n = last_ret_q;
		armed_n    = armed_q;
		popped     = 1'b0;
		case (func_t'(func_s1))
			FUNC_RAISE: begin
				if ({1'b0, irq_s1} < 5'(NS)) req_n = req_q | (NS'(1) << irq_s1);
			end
			FUNC_BOUNDARY: begin
				if (!armed_q) begin
					armed_n = 1'b1;
				end else if (pick) begin
					req_n = req_q & ~pick_one;
					case (pick_lvl)
						LVL_HIGHEST: slot_top_n = pick_one;
						LVL_HIGH:    slot_hi_n  = pick_one;
						default:     slot_lo_n  = pick_one;
					endcase
				end
			end
			FUNC_RETURN: begin
				armed_n = 1'b0;
				if (slot_top_q != '0) begin
					slot_top_n = '0;
					last_ret_n = LVL_HIGHEST;
					popped     = 1'b1;
				end else if (slot_hi_q != '0) begin
					slot_hi_n  = '0;
					last_ret_n = LVL_HIGH;
					popped     = 1'b1;
				end else if (slot_lo_q != '0) begin
					slot_lo_n  = '0;
					last_ret_n = LVL_LOW;
					popped     = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign active_n = slot_lo_n | slot_hi_n | slot_top_n;

	// Control and state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			req_q       <= '0;
			slot_lo_q   <= '0;
			slot_hi_q   <= '0;
			slot_top_q  <= '0;
			last_ret_q  <= LVL_LOW;
			armed_q     <= 1'b1;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (advance) begin
				out_valid_q <= 1'b1;
				req_q       <= req_n;
				slot_lo_q   <= slot_lo_n;
				slot_hi_q   <= slot_hi_n;
				slot_top_q  <= slot_top_n;
				last_ret_q  <= last_ret_n;
				armed_q     <= armed_n;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1 <= s_tuser;
			irq_s1  <= s_tdata[3:0];
			ie_s1   <= s_tdata[11:4];
			ip_s1   <= s_tdata[19:12];
		end
		if (advance) begin
			out_data_q <= {MaskW'(req_n), MaskW'(active_n), popped,
				(pick ? pick_lvl : LVL_LOW), (pick ? pick_idx : 4'd0), pick};
		end
	end

`include "nested_priority_interrupt_controller_assert.svh"

	`NPIC_ASSERT(a_slots_onehot, $onehot0(slot_lo_q) && $onehot0(slot_hi_q) && $onehot0(slot_top_q), "level slot holds more than one source")
	`NPIC_ASSERT(a_last_ret_range, last_ret_q != 2'd3, "last return level out of range")
	`NPIC_ASSERT_IMP(a_stall_cause, !s_tready, valid_s1 && out_valid_q && !m_tready, "input stalled without a blocked result")
	`NPIC_ASSERT_IMP(a_taken_active, out_valid_q && out_data_q[0], out_data_q[8 + out_data_q[4:1]], "accepted source missing from active mask")
	`NPIC_ASSERT_IMP(a_taken_xor_pop, out_valid_q, !(out_data_q[0] && out_data_q[7]), "accept and return in one result")

endmodule

// ===== verif/tb_nested_priority_interrupt_controller.sv =====
// Testbench for the nested priority interrupt controller: streams raise, boundary,
// return and unused-code events in and checks every result against its own predictor.
// Depends on npic_pkg and the nested_priority_interrupt_controller RTL.
`timescale 1ns / 1ps

module tb_nested_priority_interrupt_controller;
	import npic_pkg::*;

	localparam int NUM_SOURCES = NumSourcesDefault;
	localparam logic [15:0] SrcMask = 16'((32'd1 << NUM_SOURCES) - 32'd1);
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int RandomItems = 1150;
	localparam int IdleLimit = 4000;
	localparam int MaxPrinted = 50;

	typedef struct packed {
		logic [1:0] func;
		logic [3:0] irq;
		logic [7:0] ie;
		logic [7:0] ip;
	} irq_event_t;

	typedef struct packed {
		logic        taken;
		logic [3:0]  irq;
		logic [1:0]  level;
		logic        popped;
		logic [15:0] active;
		logic [15:0] pending;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	nested_priority_interrupt_controller dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #4 clk = ~clk;

	irq_event_t event_queue[$];
	outcome_t   expected_outcomes[$];
	int         error_count = 0;

	// Predicted controller state.
	logic [15:0] req_bits = '0;
	logic [15:0] slots [3] = '{16'd0, 16'd0, 16'd0};
	logic [1:0]  last_ret = LVL_LOW;
	logic        armed = 1'b1;

	function automatic logic [15:0] enabled_sources(logic [1:0] lvl, logic [7:0] ie,
			logic [7:0] ip);
		logic [15:0] m;
		m = '0;
		if (lvl == LVL_HIGHEST) begin
			m[1] = !ie[0];
			m[2] = !ie[0] && !ie[1];
		end else if (lvl == LVL_HIGH) begin
			m[3] = ip[0];
			m[4] = ip[1];
			m[5] = ip[2];
			m[6] = ip[3];
			m[7] = ip[4];
			m[8] = ip[5];
			m[10] = ip[7];
		end else if (ie[7]) begin
			// The low level takes what the priority bits leave, plus the external lines.
			m[3] = !ip[0];
			m[4] = !ip[1];
			m[5] = !ip[2];
			m[6] = !ip[3];
			m[7] = !ip[4];
			m[8] = !ip[5];
			m[10] = !ip[7];
			m[1] = ie[0];
			m[2] = ie[0] || ie[1];
		end
		return m;
	endfunction

	function automatic logic claim_source(logic [1:0] lvl, logic [7:0] ie, logic [7:0] ip,
			output logic [3:0] src);
		logic [15:0] hit;
		hit = enabled_sources(lvl, ie, ip) & req_bits & SrcMask;
		src = '0;
		for (int i = 0; i < NUM_SOURCES; i++) begin
			if (hit[i]) begin
				req_bits[i] = 1'b0;
				slots[lvl] = 16'd1 << i;
				src = i[3:0];
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic outcome_t predict_outcome(irq_event_t ev);
		outcome_t o;
		logic [3:0] src;
		o = '0;
		case (ev.func)
		FUNC_RAISE: begin
			if (ev.irq < NUM_SOURCES) req_bits[ev.irq] = 1'b1;
		end
		FUNC_BOUNDARY: begin
			if (!armed) begin
				armed = 1'b1;
			end else if ((slots[0] | slots[1] | slots[2]) == '0) begin
				// With nothing in service, the search starts below the level last returned from.
				for (int p = int'(last_ret) - 1; p >= 0 && !o.taken; p--)
					if (claim_source(p[1:0], ev.ie, ev.ip, src)) begin
						o.taken = 1'b1; o.irq = src; o.level = p[1:0];
					end
				for (int p = 1; p >= int'(last_ret) && !o.taken; p--)
					if (claim_source(p[1:0], ev.ie, ev.ip, src)) begin
						o.taken = 1'b1; o.irq = src; o.level = p[1:0];
					end
			end else begin
				for (int p = 2; p >= 0 && !o.taken; p--) begin
					if (slots[p] != '0) break;
					if (claim_source(p[1:0], ev.ie, ev.ip, src)) begin
						o.taken = 1'b1; o.irq = src; o.level = p[1:0];
					end
				end
			end
		end
		FUNC_RETURN: begin
			armed = 1'b0;
			for (int p = 2; p >= 0; p--) begin
				if (slots[p] != '0) begin
					last_ret = p[1:0];
					slots[p] = '0;
					o.popped = 1'b1;
					break;
				end
			end
		end
		default: ;
		endcase
		o.active = slots[0] | slots[1] | slots[2];
		o.pending = req_bits;
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		error_count++;
		if (error_count <= MaxPrinted)
			$display("%0t ns: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
	endtask

	function automatic void push_event(logic [1:0] func, logic [3:0] irq, logic [7:0] ie,
			logic [7:0] ip);
		irq_event_t ev;
		ev.func = func;
		ev.irq = irq;
		ev.ie = ie;
		ev.ip = ip;
		event_queue.push_back(ev);
	endfunction

	// Driver: sends bursts of events separated by random gaps.
	int         burst_left;
	int         gap_left;
	irq_event_t next_event;
	irq_event_t sent_event;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				sent_event.func = s_tuser;
				sent_event.irq = s_tdata[3:0];
				sent_event.ie = s_tdata[11:4];
				sent_event.ip = s_tdata[19:12];
				expected_outcomes.push_back(predict_outcome(sent_event));
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (event_queue.size() == 0) begin
					s_tvalid <= 1'b0;
				end else begin
					next_event = event_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= next_event.func;
					s_tdata <= {4'd0, next_event.ip, next_event.ie, next_event.irq};
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left <= burst_left - 1;
					end
				end
			end
		end
	end

	// Monitor: stalls in modes of random length and checks each transfer.
	int       stall_mode;
	int       mode_left;
	outcome_t got_outcome;
	outcome_t want_outcome;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_mode <= 0;
			mode_left <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_outcome.taken = m_tdata[0];
				got_outcome.irq = m_tdata[4:1];
				got_outcome.level = m_tdata[6:5];
				got_outcome.popped = m_tdata[7];
				got_outcome.active = m_tdata[23:8];
				got_outcome.pending = m_tdata[39:24];
				if (expected_outcomes.size() == 0) begin
					report_mismatch("unexpected result", m_tdata[15:0], '0);
				end else begin
					want_outcome = expected_outcomes.pop_front();
					if (got_outcome.taken !== want_outcome.taken)
						report_mismatch("taken", 16'(got_outcome.taken),
							16'(want_outcome.taken));
					if (got_outcome.irq !== want_outcome.irq)
						report_mismatch("taken_irq", 16'(got_outcome.irq),
							16'(want_outcome.irq));
					if (got_outcome.level !== want_outcome.level)
						report_mismatch("taken_level", 16'(got_outcome.level),
							16'(want_outcome.level));
					if (got_outcome.popped !== want_outcome.popped)
						report_mismatch("reti_popped", 16'(got_outcome.popped),
							16'(want_outcome.popped));
					if (got_outcome.active !== want_outcome.active)
						report_mismatch("active_mask", got_outcome.active, want_outcome.active);
					if (got_outcome.pending !== want_outcome.pending)
						report_mismatch("pending_mask", got_outcome.pending,
							want_outcome.pending);
				end
			end
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				mode_left <= $urandom_range(8, 60);
				m_tready <= 1'b1;
			end else begin
				mode_left <= mode_left - 1;
				case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= (mode_left[1:0] == 2'd0);
				default: m_tready <= (mode_left[3:0] == 4'd0);
				endcase
			end
		end
	end

	// Watchdog on cycles without any transfer.
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IdleLimit) begin
				$display("FAIL nested_priority_interrupt_controller");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int          w;
		logic [3:0]  n;
		logic [7:0]  ie;
		logic [7:0]  ip;

		// Directed part: boundary with nothing pending, never-enabled sources, a nested
		// take at the highest level, a skipped boundary after a return, a return with
		// nothing in service, the unused event code and the field extremes.
		push_event(FUNC_BOUNDARY, 4'd0, 8'h00, 8'h00);
		push_event(FUNC_RAISE, 4'd15, 8'hFF, 8'hFF);
		push_event(FUNC_RAISE, 4'd0, 8'h00, 8'h00);
		push_event(FUNC_RAISE, 4'd9, 8'hFF, 8'h00);
		push_event(FUNC_RAISE, 4'd3, 8'h00, 8'h00);
		push_event(FUNC_BOUNDARY, 4'd0, 8'h80, 8'h00);
		push_event(FUNC_RAISE, 4'd1, 8'h00, 8'h00);
		push_event(FUNC_BOUNDARY, 4'd15, 8'h00, 8'h00);
		push_event(FUNC_RAISE, 4'd4, 8'hFF, 8'hFF);
		push_event(FUNC_BOUNDARY, 4'd0, 8'hFF, 8'hFF);
		push_event(FUNC_RETURN, 4'd0, 8'h00, 8'h00);
		push_event(FUNC_BOUNDARY, 4'd0, 8'hFF, 8'hFF);
		push_event(FUNC_BOUNDARY, 4'd0, 8'hFF, 8'hFF);
		push_event(FUNC_RETURN, 4'd15, 8'hFF, 8'hFF);
		push_event(FUNC_RETURN, 4'd0, 8'h00, 8'h00);
		push_event(FUNC_RETURN, 4'd0, 8'h00, 8'h00);
		push_event(FUNC_BOUNDARY, 4'd0, 8'h00, 8'h00);
		push_event(FUNC_UNUSED, 4'd15, 8'hFF, 8'hFF);
		push_event(FUNC_RAISE, 4'd10, 8'h00, 8'h00);
		push_event(FUNC_RAISE, 4'd2, 8'h00, 8'h00);
		push_event(FUNC_BOUNDARY, 4'd0, 8'h7F, 8'h00);
		push_event(FUNC_BOUNDARY, 4'd0, 8'h82, 8'h80);
		push_event(FUNC_RETURN, 4'd0, 8'h00, 8'h00);
		push_event(FUNC_BOUNDARY, 4'd0, 8'h83, 8'h00);
		push_event(FUNC_BOUNDARY, 4'd0, 8'h83, 8'h00);

		// Random part: raises, mostly of live sources, mixed with boundaries, returns and
		// unused codes, so that requests nest across all three levels.
		for (int k = 0; k < RandomItems; k++) begin
			w = $urandom_range(0, 99);
			if ($urandom_range(0, 4) == 0) begin
				n = 4'($urandom_range(0, 15));
			end else begin
				n = 4'($urandom_range(1, 9));
				if (n == 4'd9) n = 4'd10;
			end
			ie = 8'($urandom);
			if ($urandom_range(0, 4) != 0) ie[7] = 1'b1;
			ip = 8'($urandom);
			if (w < 36) push_event(FUNC_RAISE, n, ie, ip);
			else if (w < 72) push_event(FUNC_BOUNDARY, n, ie, ip);
			else if (w < 95) push_event(FUNC_RETURN, n, ie, ip);
			else push_event(FUNC_UNUSED, n, ie, ip);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (event_queue.size() != 0 || s_tvalid) @(posedge clk);
		while (expected_outcomes.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (error_count == 0) begin
			$display("PASS nested_priority_interrupt_controller");
		end else begin
			$display("FAIL nested_priority_interrupt_controller");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/npic_pkg.sv
rtl/core/nested_priority_interrupt_controller.sv
verif/tb_nested_priority_interrupt_controller.sv
